@@ hdl/clt_pkg.sv @@
package clt_pkg;

  // Field widths of the stream words.
  localparam int unsigned CharW   = 8;
  localparam int unsigned KindW   = 2;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 4;
  localparam int unsigned StateW  = 3;

  // Packed word widths; the data words are rounded up to whole bytes.
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned OutUserW = 3;

  // Register file.
  localparam int unsigned AddrW = 3;
  localparam logic [AddrW-1:0] AddrParseArgs = 3'd0;
  localparam logic [AddrW-1:0] AddrMaxArgs   = 3'd4;

  // Largest argument count the block can hold.
  localparam logic [CountW-1:0] MaxArgs = 4'd8;

  // Scanner states.
  localparam logic [StateW-1:0] StFindCmd   = 3'd0;
  localparam logic [StateW-1:0] StParseCmd  = 3'd1;
  localparam logic [StateW-1:0] StFindSlash = 3'd2;
  localparam logic [StateW-1:0] StFindArg   = 3'd3;
  localparam logic [StateW-1:0] StParseArg  = 3'd4;
  localparam logic [StateW-1:0] StFindVal   = 3'd5;
  localparam logic [StateW-1:0] StParseVal  = 3'd6;

  // Token kinds.
  localparam logic [KindW-1:0] KindSep   = 2'd0;
  localparam logic [KindW-1:0] KindCmd   = 2'd1;
  localparam logic [KindW-1:0] KindName  = 2'd2;
  localparam logic [KindW-1:0] KindValue = 2'd3;

  // Line status codes.
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusNoCmd   = 2'd1;
  localparam logic [StatusW-1:0] StatusTooMany = 2'd2;

  // Character codes.
  localparam logic [CharW-1:0] ChDquote = 8'd34;
  localparam logic [CharW-1:0] ChSquote = 8'd39;
  localparam logic [CharW-1:0] ChSpace  = 8'd32;
  localparam logic [CharW-1:0] ChSlash  = 8'd47;
  localparam logic [CharW-1:0] ChUpperA = 8'd65;
  localparam logic [CharW-1:0] ChUpperZ = 8'd90;
  localparam logic [CharW-1:0] CaseOfs  = 8'd32;

  typedef struct packed {
    logic              parse_args;
    logic [CountW-1:0] max_args;
  } cfg_t;

  typedef struct packed {
    logic [CharW-1:0]   char_out;
    logic [KindW-1:0]   token_kind;
    logic               token_start;
    logic [IdxW-1:0]    arg_index;
    logic               line_done;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  arg_count;
  } res_t;

endpackage

@@ hdl/clt_cfg.sv @@
module clt_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [clt_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output clt_pkg::cfg_t             cfg_o
);
  import clt_pkg::*;

  logic              parse_args_q;
  logic [CountW-1:0] max_args_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes in the access cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_args_q <= 1'b1;
      max_args_q   <= MaxArgs;
    end else if (wr_en) begin
      if (paddr == AddrParseArgs) begin
        parse_args_q <= pwdata[0];
      end
      if (paddr == AddrMaxArgs) begin
        max_args_q <= pwdata[CountW-1:0];
      end
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    case (paddr)
      AddrParseArgs: prdata[0] = parse_args_q;
      AddrMaxArgs:   prdata[CountW-1:0] = max_args_q;
      default:       prdata = '0;
    endcase
  end

  assign cfg_o.parse_args = parse_args_q;
  assign cfg_o.max_args   = max_args_q;

endmodule

@@ hdl/clt_scan.sv @@
module clt_scan (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  clt_pkg::cfg_t             cfg_i,
  input  logic                      push_i,
  input  logic [clt_pkg::CharW-1:0] char_i,
  input  logic                      end_line_i,
  output clt_pkg::res_t             res_o
);
  import clt_pkg::*;

  logic [StateW-1:0] state_q, state_d;
  logic              quotes_q, quotes_d;
  logic [CountW-1:0] args_q, args_d;
  logic              cmd_q, cmd_d;
  logic              halted_q, halted_d;
  logic              ovf_q, ovf_d;

  logic [CharW-1:0]  ch;
  logic [CountW-1:0] limit;
  logic [CountW-1:0] idx_full;
  logic [KindW-1:0]  kind;
  logic              start;
  logic              is_space;
  logic              is_quote;

  // Character mapping: lower case outside values, control bytes to space.
  always_comb begin
    ch = char_i;
    if (state_q != StFindVal && state_q != StParseVal &&
        char_i >= ChUpperA && char_i <= ChUpperZ) begin
      ch = char_i + CaseOfs;
    end
    if (ch < ChSpace) begin
      ch = ChSpace;
    end
  end

  assign is_space = (ch == ChSpace);
  assign is_quote = (ch == ChDquote) || (ch == ChSquote);
  assign limit    = (cfg_i.max_args > MaxArgs) ? MaxArgs : cfg_i.max_args;

  // Next state and token tag for a character.
  always_comb begin
    state_d  = state_q;
    quotes_d = quotes_q;
    args_d   = args_q;
    cmd_d    = cmd_q;
    halted_d = halted_q;
    ovf_d    = ovf_q;
    kind     = KindSep;
    start    = 1'b0;
    if (!halted_q) begin
      case (state_q)
        StFindCmd: begin
          if (!is_space) begin
            kind    = KindCmd;
            start   = 1'b1;
            cmd_d   = 1'b1;
            state_d = StParseCmd;
          end
        end
        StParseCmd: begin
          if (is_space) begin
            if (!cfg_i.parse_args) begin
              halted_d = 1'b1;
            end else begin
              state_d = StFindSlash;
            end
          end else begin
            kind = KindCmd;
          end
        end
        StFindSlash: begin
          if (ch == ChSlash) begin
            state_d = StFindArg;
          end
        end
        StFindArg: begin
          if (!is_space) begin
            if (args_q >= limit) begin
              ovf_d    = 1'b1;
              halted_d = 1'b1;
            end else begin
              args_d  = args_q + 1'b1;
              kind    = KindName;
              start   = 1'b1;
              state_d = StParseArg;
            end
          end
        end
        StParseArg: begin
          if (is_space) begin
            state_d  = StFindVal;
            quotes_d = 1'b0;
          end else begin
            kind = KindName;
          end
        end
        StFindVal: begin
          if (!is_space) begin
            kind     = KindValue;
            start    = 1'b1;
            quotes_d = is_quote;
            state_d  = StParseVal;
          end
        end
        StParseVal: begin
          if (quotes_q) begin
            kind = KindValue;
            if (is_quote) begin
              quotes_d = 1'b0;
            end
          end else if (is_space) begin
            state_d = StFindSlash;
          end else begin
            kind = KindValue;
          end
        end
        default: state_d = StFindCmd;
      endcase
    end
  end

  assign idx_full = args_d - 1'b1;

  // Result word for the current input.
  always_comb begin
    res_o = '0;
    if (end_line_i) begin
      res_o.line_done = 1'b1;
      res_o.status    = ovf_q ? StatusTooMany : (cmd_q ? StatusOk : StatusNoCmd);
      res_o.arg_count = args_q;
    end else begin
      res_o.char_out    = ch;
      res_o.token_kind  = kind;
      res_o.token_start = start;
      if ((kind == KindName || kind == KindValue) && args_d != '0) begin
        res_o.arg_index = idx_full[IdxW-1:0];
      end
    end
  end

  // Line state, cleared by an end of line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StFindCmd;
      quotes_q <= 1'b0;
      args_q   <= '0;
      cmd_q    <= 1'b0;
      halted_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else if (push_i) begin
      if (end_line_i) begin
        state_q  <= StFindCmd;
        quotes_q <= 1'b0;
        args_q   <= '0;
        cmd_q    <= 1'b0;
        halted_q <= 1'b0;
        ovf_q    <= 1'b0;
      end else begin
        state_q  <= state_d;
        quotes_q <= quotes_d;
        args_q   <= args_d;
        cmd_q    <= cmd_d;
        halted_q <= halted_d;
        ovf_q    <= ovf_d;
      end
    end
  end

endmodule

@@ hdl/clt_outbuf.sv @@
module clt_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  clt_pkg::res_t in_res_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output clt_pkg::res_t out_res_o
);
  import clt_pkg::*;

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic push;

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk_i) begin
    if (out_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= in_res_i;
      end
    end else if (push) begin
      skid_q <= in_res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

@@ hdl/command_line_tokenizer.sv @@
// Console line tokenizer. Each input word carries one byte of a line in
// tdata, and tlast set marks the end of the line instead of a byte. Every
// input word yields exactly one output word, registered in the output stage or
// held in the skid entry, and a new word is accepted in every cycle while the
// output side keeps up; the only limit is the single scanner state update per
// byte, and a one-word skid stage takes one more word while output is stalled.
// Byte results carry the mapped character, token kind, token start and
// argument index; the end-of-line result (tlast) carries the line status and
// argument count and clears the line state. Configure parse_args (0x0) and
// max_args (0x4) only while the stream is idle.
module command_line_tokenizer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration port.
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clt_pkg::AddrW-1:0]    paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // Input stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [clt_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] char_in
  input  logic                         s_axis_tlast,  // end_line
  // Output stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] char_out, [10:8] arg_index, [12:11] status, [16:13] arg_count
  output logic [clt_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] token_kind, [2] token_start
  output logic [clt_pkg::OutUserW-1:0] m_axis_tuser,
  output logic                         m_axis_tlast   // line_done
);
  import clt_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic push;

  assign push = s_axis_tvalid && s_axis_tready;

  clt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  clt_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push_i     (push),
    .char_i     (s_axis_tdata[CharW-1:0]),
    .end_line_i (s_axis_tlast),
    .res_o      (res)
  );

  clt_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  // Pack the result word.
  assign m_axis_tdata = {7'd0, out_res.arg_count, out_res.status,
                         out_res.arg_index, out_res.char_out};
  assign m_axis_tuser = {out_res.token_start, out_res.token_kind};
  assign m_axis_tlast = out_res.line_done;

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clt_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int LongStall  = 300;
  localparam int PhaseItems = 290;
  localparam int NumPhases  = 6;
  localparam int MaxReports = 10;

  // Register settings and idle pattern of each random phase.
  localparam logic       PhaseParse [NumPhases] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam logic [3:0] PhaseMax   [NumPhases] = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd5};
  localparam int         SendIdle   [4]         = '{0, 83, 0, 11};
  localparam int         RecvStall  [4]         = '{0, 0, 83, 11};

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [31:0]         pwdata        = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // [7:0] char_in
  logic                s_axis_tlast  = 1'b0;  // end_line
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [7:0] char_out, [10:8] arg_index, [12:11] status, [16:13] arg_count
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;  // [1:0] token_kind, [2] token_start
  logic                m_axis_tlast;  // line_done

  command_line_tokenizer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Pending input words: {end_line, char_in}.
  logic [8:0] pending_chars[$];
  res_t       expected_tokens[$];

  int   pushed_items   = 0;
  int   mismatches     = 0;
  int   reg_errors     = 0;
  int   cycles         = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   stall_request  = 0;
  int   stall_served   = 0;
  int   stall_left     = 0;
  logic send_hold      = 1'b0;
  logic in_fire        = 1'b0;

  // Scanner state of the line being predicted, and the register copies.
  logic [StateW-1:0] scan_st    = StFindCmd;
  logic              quoted     = 1'b0;
  logic [CountW-1:0] nargs      = '0;
  logic              cmd_seen   = 1'b0;
  logic              halted_q   = 1'b0;
  logic              overflow_q = 1'b0;
  logic              cfg_parse  = 1'b1;
  logic [CountW-1:0] cfg_max    = MaxArgs;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Works out the result word of one input word and advances the line state.
  function automatic res_t predict_token(logic [CharW-1:0] ch, logic eol);
    res_t              r;
    logic [CharW-1:0]  c;
    logic [CountW-1:0] lim;
    logic [CountW-1:0] prev;
    r = '0;
    if (eol) begin
      r.line_done = 1'b1;
      r.status    = overflow_q ? StatusTooMany : (cmd_seen ? StatusOk : StatusNoCmd);
      r.arg_count = nargs;
      scan_st     = StFindCmd;
      quoted      = 1'b0;
      nargs       = '0;
      cmd_seen    = 1'b0;
      halted_q    = 1'b0;
      overflow_q  = 1'b0;
      return r;
    end
    c = ch;
    // Letters fold to lower case everywhere except inside a value.
    if (scan_st != StFindVal && scan_st != StParseVal && c >= ChUpperA && c <= ChUpperZ)
      c = c + CaseOfs;
    if (c < ChSpace)
      c = ChSpace;
    lim = (cfg_max > MaxArgs) ? MaxArgs : cfg_max;
    r.char_out = c;
    if (!halted_q) begin
      case (scan_st)
        StFindCmd: begin
          if (c != ChSpace) begin
            r.token_kind  = KindCmd;
            r.token_start = 1'b1;
            cmd_seen      = 1'b1;
            scan_st       = StParseCmd;
          end
        end
        StParseCmd: begin
          if (c == ChSpace) begin
            if (!cfg_parse) halted_q = 1'b1;
            else scan_st = StFindSlash;
          end else begin
            r.token_kind = KindCmd;
          end
        end
        StFindSlash: begin
          if (c == ChSlash) scan_st = StFindArg;
        end
        StFindArg: begin
          if (c != ChSpace) begin
            // One argument past the limit stops the line with an error.
            if (nargs >= lim) begin
              overflow_q = 1'b1;
              halted_q   = 1'b1;
            end else begin
              nargs         = nargs + 1'b1;
              r.token_kind  = KindName;
              r.token_start = 1'b1;
              scan_st       = StParseArg;
            end
          end
        end
        StParseArg: begin
          if (c == ChSpace) begin
            scan_st = StFindVal;
            quoted  = 1'b0;
          end else begin
            r.token_kind = KindName;
          end
        end
        StFindVal: begin
          if (c != ChSpace) begin
            r.token_kind  = KindValue;
            r.token_start = 1'b1;
            quoted        = (c == ChDquote || c == ChSquote);
            scan_st       = StParseVal;
          end
        end
        StParseVal: begin
          // A quoted value runs to the next quote of either kind.
          if (quoted) begin
            r.token_kind = KindValue;
            if (c == ChDquote || c == ChSquote) quoted = 1'b0;
          end else if (c == ChSpace) begin
            scan_st = StFindSlash;
          end else begin
            r.token_kind = KindValue;
          end
        end
        default: begin
          scan_st = StFindCmd;
        end
      endcase
    end
    if ((r.token_kind == KindName || r.token_kind == KindValue) && nargs != 0) begin
      prev        = nargs - 1'b1;
      r.arg_index = prev[IdxW-1:0];
    end
    return r;
  endfunction

  // Monitor: checks each output word against the oldest expectation, then
  // records the expectation of an input word taken at the same edge.
  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        got.char_out    = m_axis_tdata[7:0];
        got.arg_index   = m_axis_tdata[10:8];
        got.status      = m_axis_tdata[12:11];
        got.arg_count   = m_axis_tdata[16:13];
        got.token_kind  = m_axis_tuser[1:0];
        got.token_start = m_axis_tuser[2];
        got.line_done   = m_axis_tlast;
        if (expected_tokens.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MaxReports)
            $display("unexpected output word: char %02h kind %0d done %0b",
                     got.char_out, got.token_kind, got.line_done);
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= MaxReports) begin
              $write("mismatch: expected char %02h kind %0d start %0b idx %0d ",
                     want.char_out, want.token_kind, want.token_start, want.arg_index);
              $write("done %0b status %0d count %0d, ",
                     want.line_done, want.status, want.arg_count);
              $write("got char %02h kind %0d start %0b idx %0d ",
                     got.char_out, got.token_kind, got.token_start, got.arg_index);
              $display("done %0b status %0d count %0d",
                       got.line_done, got.status, got.arg_count);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_tokens.push_back(predict_token(s_axis_tdata[CharW-1:0], s_axis_tlast));
    end
  end

  // Driver: holds a word until it is taken, then offers the next one or idles.
  always @(negedge clk_i) begin : driver
    logic [8:0] next_word;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pending_chars.size() != 0 && !send_hold &&
          $urandom_range(99) >= send_idle_pct) begin
        next_word = pending_chars.pop_front();
        s_axis_tdata  <= next_word[7:0];
        s_axis_tlast  <= next_word[8];
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk_i) begin
    if (stall_served != stall_request) begin
      stall_served  <= stall_request;
      stall_left    <= LongStall;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** command_line_tokenizer: FAILED **");
      $finish;
    end
  end

  task automatic push_char(logic [7:0] b);
    pending_chars.push_back({1'b0, b});
    pushed_items++;
  endtask

  task automatic push_eol();
    pending_chars.push_back({1'b1, 8'($urandom_range(255))});
    pushed_items++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i]);
  endtask

  // Characters of a word: mostly letters of both cases, some digits and
  // punctuation, and some bytes above 127.
  function automatic logic [7:0] word_char();
    logic [7:0] b;
    case ($urandom_range(9))
      0, 1, 2, 3: b = 8'd97 + 8'($urandom_range(25));
      4, 5, 6:    b = ChUpperA + 8'($urandom_range(25));
      7:          b = 8'd48 + 8'($urandom_range(9));
      8:          b = 8'($urandom_range(128, 255));
      default: begin
        b = 8'($urandom_range(33, 126));
        if (b == ChSlash || b == ChDquote || b == ChSquote) b = 8'd120;
      end
    endcase
    return b;
  endfunction

  task automatic push_word();
    repeat ($urandom_range(1, 5)) push_char(word_char());
  endtask

  // Separator run; a control byte counts as a space.
  task automatic push_gap();
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(9) == 0) push_char(8'($urandom_range(31)));
      else push_char(ChSpace);
    end
  endtask

  function automatic logic [7:0] any_quote();
    return $urandom_range(1) ? ChDquote : ChSquote;
  endfunction

  // One random line: mostly a command with slash arguments, some noise.
  task automatic gen_line();
    int n_args;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(3))
          0:       push_char(8'($urandom_range(255)));
          1:       push_char(ChSlash);
          2:       push_char(ChSpace);
          default: push_char(any_quote());
        endcase
      end
    end else begin
      if ($urandom_range(3) == 0) push_gap();
      if ($urandom_range(19) != 0) push_word();
      n_args = ($urandom_range(4) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 3);
      for (int a = 0; a < n_args; a++) begin
        push_gap();
        push_char(ChSlash);
        if ($urandom_range(4) == 0) push_char(ChSpace);
        push_word();
        if ($urandom_range(4) != 0) begin
          push_gap();
          if ($urandom_range(2) == 0) begin
            // Quoted value, sometimes with an inner space; sometimes left unclosed.
            push_char(any_quote());
            push_word();
            if ($urandom_range(1)) begin
              push_char(ChSpace);
              push_word();
            end
            if ($urandom_range(9) != 0) push_char(any_quote());
          end else begin
            push_word();
          end
        end
      end
      if ($urandom_range(9) < 3) push_gap();
    end
    push_eol();
  endtask

  // Register write followed by a read back of the same register.
  task automatic program_reg(logic [AddrW-1:0] addr, logic [31:0] value, logic [31:0] mask);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== (value & mask)) begin
      reg_errors++;
      $display("register %0d read back %08h, expected %08h", addr, rd & mask, value & mask);
    end
  endtask

  task automatic set_config(logic pa, logic [CountW-1:0] mx);
    program_reg(AddrParseArgs, {31'd0, pa}, 32'h1);
    program_reg(AddrMaxArgs, {28'd0, mx}, 32'hF);
    cfg_parse = pa;
    cfg_max   = mx;
  endtask

  // Waits until the stream is empty, then lets the pipeline settle.
  task automatic wait_idle();
    while (pending_chars.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    int start_count;
    int drain_cycles;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty line, control bytes, quoted value closed by the other
    // quote kind, and one argument over a limit of two.
    set_config(1'b1, 4'd2);
    @(posedge clk_i);
    push_eol();
    push_char(8'h00);
    push_char(8'h1F);
    push_text("Go /Ab 'x Y");
    push_char(ChDquote);
    push_text(" /b \"Q\" /c");
    push_eol();
    wait_idle();

    // Directed: no argument parsing, high bytes in the command word.
    set_config(1'b0, 4'd8);
    @(posedge clk_i);
    push_text("Zq");
    push_char(8'hFF);
    push_char(8'h80);
    push_text(" q /a");
    push_eol();

    // Random phases over several settings and idle patterns.
    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      set_config(PhaseParse[phase], PhaseMax[phase]);
      @(posedge clk_i);
      send_idle_pct  = SendIdle[phase % 4];
      recv_stall_pct = RecvStall[phase % 4];
      start_count    = pushed_items;
      while (pushed_items - start_count < PhaseItems)
        gen_line();
      // Long receiver hold-off while the sender keeps offering words.
      if (phase == 0) stall_request++;
      // Sender pause until everything sent has come out.
      if (phase == 1) begin
        while (pending_chars.size() > PhaseItems / 2) @(posedge clk_i);
        send_hold = 1'b1;
        while (s_axis_tvalid || expected_tokens.size() != 0) @(posedge clk_i);
        repeat (5) @(posedge clk_i);
        send_hold = 1'b0;
      end
    end

    drain_cycles = 0;
    while ((pending_chars.size() != 0 || s_axis_tvalid || expected_tokens.size() != 0) &&
           drain_cycles < 100000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (expected_tokens.size() != 0)
      $display("%0d expected words never arrived", expected_tokens.size());
    if (mismatches == 0 && reg_errors == 0 && expected_tokens.size() == 0 &&
        pending_chars.size() == 0) begin
      $display("** command_line_tokenizer: PASSED **");
    end else begin
      $display("** command_line_tokenizer: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/clt_pkg.sv
hdl/clt_cfg.sv
hdl/clt_scan.sv
hdl/clt_outbuf.sv
hdl/command_line_tokenizer.sv
tb/tb.sv
